FILE: hw/rtl/swm_pkg.sv
// swm_pkg: shared types and constants for the subject wildcard matcher
// depends on nothing; used by swm_front, swm_back and the top level

package swm_pkg;

  localparam int PATTERN_CHARS_DEF = 64;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_GT   = 8'h3E;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_SUBJECT = 1'b1;

  localparam logic [1:0] OUT_NOMATCH  = 2'd0;
  localparam logic [1:0] OUT_MATCH    = 2'd1;
  localparam logic [1:0] OUT_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    V_RUNNING = 2'd0,
    V_NOMATCH = 2'd1,
    V_MATCH   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PH_MAIN = 2'd0,
    PH_END  = 2'd1,
    PH_FIN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       is_load;
    logic       is_dot;
    logic       last;
    logic [7:0] symbol;
  } item_t;

endpackage

FILE: hw/rtl/swm_ram.sv
// swm_ram: generic single write port ram with registered read
// depends on nothing

module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/swm_front.sv
// swm_front: accepts input transactions, classifies them and queues them
// depends on swm_pkg (item_t, QUEUE_DEPTH, character and function codes)

module swm_front import swm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_symbol,
  input  logic       in_last,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q_r [QUEUE_DEPTH];
  item_t            in_item;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  // classification
  always_comb begin
    in_item.is_load = (in_func == FUNC_LOAD);
    in_item.is_dot  = (in_symbol == CH_DOT);
    in_item.last    = in_last;
    in_item.symbol  = in_symbol;
  end

  assign in_ready   = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: hw/rtl/swm_back.sv
// swm_back: pattern store, element matcher and result register
// depends on swm_pkg (item_t, verdict_t, phase_t, codes) and swm_ram

module swm_back import swm_pkg::*; #(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_outcome
);

  localparam int ADDR_W = $clog2(PATTERN_CHARS);
  localparam int LEN_W  = $clog2(PATTERN_CHARS + 1);
  localparam int POS_W  = $clog2(PATTERN_CHARS + 2);

  logic [LEN_W-1:0]  len_r, len_nxt, len_eff;
  logic              too_long_r, too_long_nxt;
  logic              fresh_r, fresh_nxt;
  logic [POS_W-1:0]  mp_r, mp_nxt, mp_sel, len_p;
  logic [POS_W:0]    mp_inc1, mp_inc2;
  logic              es_r, es_nxt;
  logic              skip_r, skip_nxt;
  verdict_t          vd_r, vd_nxt;
  phase_t            phase_r, phase_nxt;
  logic              out_valid_r;
  logic [1:0]        out_outcome_r, res_outcome;

  logic              ch_we, fl_we, ch_we_f, fl_we_f;
  logic [ADDR_W-1:0] ch_waddr, fl_waddr, raddr;
  logic [7:0]        ch_rdata, ch_byp_r, ch_q;
  logic              fl_rdata, fl_byp_r, fl_q;
  logic              ch_hit_r, fl_hit_r;

  logic              in_pat, past_end, next_end, el_single;
  logic              el_gt, el_plus, el_star, ch_is_dot;
  logic              res_valid, item_done, slot_free, fire;

  // pattern store: characters, and per entry whether the next character is a dot
  swm_ram #(.WIDTH(8), .DEPTH(PATTERN_CHARS)) u_char_ram (
    .clk   (clk),
    .we    (ch_we_f),
    .waddr (ch_waddr),
    .wdata (item.symbol),
    .raddr (raddr),
    .rdata (ch_rdata)
  );

  swm_ram #(.WIDTH(1), .DEPTH(PATTERN_CHARS)) u_flag_ram (
    .clk   (clk),
    .we    (fl_we_f),
    .waddr (fl_waddr),
    .wdata (item.is_dot),
    .raddr (raddr),
    .rdata (fl_rdata)
  );

  assign ch_q = ch_hit_r ? ch_byp_r : ch_rdata;
  assign fl_q = fl_hit_r ? fl_byp_r : fl_rdata;

  // classification of the pattern element at the match position
  always_comb begin
    len_p     = POS_W'(len_r);
    mp_inc1   = {1'b0, mp_r} + (POS_W + 1)'(1);
    mp_inc2   = {1'b0, mp_r} + (POS_W + 1)'(2);
    in_pat    = (mp_r < len_p);
    past_end  = (mp_r > len_p);
    next_end  = (mp_inc1 >= {1'b0, len_p});
    el_single = in_pat && (next_end || fl_q);
    el_gt     = el_single && (ch_q == CH_GT);
    el_plus   = el_single && (ch_q == CH_PLUS);
    el_star   = el_single && (ch_q == CH_STAR);
    ch_is_dot = (ch_q == CH_DOT);
  end

  assign len_eff  = fresh_r ? '0 : len_r;
  assign ch_waddr = ADDR_W'(len_eff);
  assign fl_waddr = ADDR_W'(len_eff - LEN_W'(1));

  always_comb begin
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    fresh_nxt    = fresh_r;
    mp_nxt       = mp_r;
    es_nxt       = es_r;
    skip_nxt     = skip_r;
    vd_nxt       = vd_r;
    ch_we        = 1'b0;
    fl_we        = 1'b0;
    res_valid    = 1'b0;
    item_done    = 1'b1;
    res_outcome  = OUT_NOMATCH;
    if (item.is_load) begin
      too_long_nxt = fresh_r ? 1'b0 : too_long_r;
      fresh_nxt    = item.last;
      len_nxt      = len_eff;
      if (len_eff < LEN_W'(PATTERN_CHARS)) begin
        ch_we   = 1'b1;
        fl_we   = (len_eff != '0);
        len_nxt = len_eff + LEN_W'(1);
      end else begin
        too_long_nxt = 1'b1;
      end
      mp_nxt   = '0;
      es_nxt   = 1'b1;
      skip_nxt = 1'b0;
      vd_nxt   = V_RUNNING;
    end else begin
      unique case (phase_r)
        PH_MAIN: begin
          if (vd_r == V_RUNNING) begin
            if (es_r) begin
              es_nxt = 1'b0;
              if (past_end) begin
                vd_nxt = V_NOMATCH;
              end else if (el_gt || el_plus) begin
                vd_nxt = V_MATCH;
              end else if (el_star) begin
                skip_nxt = 1'b1;
              end
            end
            if (vd_nxt == V_RUNNING) begin
              if (item.is_dot) begin
                if (skip_nxt) begin
                  mp_nxt = POS_W'(mp_inc2);
                end else if (in_pat && !ch_is_dot) begin
                  vd_nxt = V_NOMATCH;
                end else begin
                  mp_nxt = POS_W'(mp_inc1);
                end
                skip_nxt = 1'b0;
                es_nxt   = 1'b1;
              end else if (!skip_nxt) begin
                if (in_pat && (ch_q == item.symbol)) begin
                  mp_nxt = POS_W'(mp_inc1);
                end else begin
                  vd_nxt = V_NOMATCH;
                end
              end
            end
          end
          if (item.last) begin
            if (vd_nxt == V_RUNNING) begin
              item_done = 1'b0;
            end else begin
              res_valid = 1'b1;
            end
          end
        end
        PH_END: begin
          item_done = 1'b0;
          if (vd_r == V_RUNNING) begin
            // trailing dot opens a final empty element
            if (item.is_dot) begin
              if (past_end) begin
                vd_nxt = V_NOMATCH;
              end else if (el_gt || el_plus) begin
                vd_nxt = V_MATCH;
              end else if (el_star) begin
                skip_nxt = 1'b1;
              end
            end
            if (vd_nxt == V_RUNNING) begin
              if (skip_nxt) begin
                mp_nxt = POS_W'(mp_inc2);
              end else if (in_pat && !ch_is_dot) begin
                vd_nxt = V_NOMATCH;
              end else begin
                mp_nxt = POS_W'(mp_inc1);
              end
              skip_nxt = 1'b0;
            end
          end
        end
        PH_FIN: begin
          if (vd_r == V_RUNNING) begin
            vd_nxt = (past_end || el_plus) ? V_MATCH : V_NOMATCH;
          end
          res_valid = 1'b1;
        end
        default: begin
          item_done = 1'b1;
        end
      endcase
      if (res_valid) begin
        if (too_long_r) begin
          res_outcome = OUT_OVERFLOW;
        end else if (vd_nxt == V_MATCH) begin
          res_outcome = OUT_MATCH;
        end else begin
          res_outcome = OUT_NOMATCH;
        end
        mp_nxt   = '0;
        es_nxt   = 1'b1;
        skip_nxt = 1'b0;
        vd_nxt   = V_RUNNING;
      end
    end
  end

  assign slot_free  = !out_valid_r || out_ready;
  assign fire       = item_valid && (!res_valid || slot_free);
  assign item_ready = fire && item_done;
  assign ch_we_f    = fire && ch_we;
  assign fl_we_f    = fire && fl_we;
  assign mp_sel     = fire ? mp_nxt : mp_r;
  assign raddr      = ADDR_W'(mp_sel);

  // tail of a final subject character
  always_comb begin
    phase_nxt = phase_r;
    if (fire && !item.is_load) begin
      unique case (phase_r)
        PH_MAIN: begin
          if (!item_done) begin
            phase_nxt = PH_END;
          end
        end
        PH_END:  phase_nxt = PH_FIN;
        PH_FIN:  phase_nxt = PH_MAIN;
        default: phase_nxt = PH_MAIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      too_long_r  <= 1'b0;
      fresh_r     <= 1'b1;
      mp_r        <= '0;
      es_r        <= 1'b1;
      skip_r      <= 1'b0;
      vd_r        <= V_RUNNING;
      phase_r     <= PH_MAIN;
      out_valid_r <= 1'b0;
      ch_hit_r    <= 1'b0;
      fl_hit_r    <= 1'b0;
    end else begin
      if (fire) begin
        len_r      <= len_nxt;
        too_long_r <= too_long_nxt;
        fresh_r    <= fresh_nxt;
        mp_r       <= mp_nxt;
        es_r       <= es_nxt;
        skip_r     <= skip_nxt;
        vd_r       <= vd_nxt;
      end
      phase_r <= phase_nxt;
      if (fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      ch_hit_r <= ch_we_f && (ch_waddr == raddr);
      fl_hit_r <= fl_we_f && (fl_waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_outcome_r <= res_outcome;
    end
    ch_byp_r <= item.symbol;
    fl_byp_r <= item.is_dot;
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;

endmodule

FILE: hw/rtl/subject_wildcard_match_core.sv
// subject_wildcard_match_core: top level of the dotted subject wildcard matcher
// depends on swm_pkg, swm_front and swm_back

// Pattern characters (func 0) and subject characters (func 1) enter through a
// four-entry queue, so in_ready depends only on queue fill. Each pattern
// character and each subject character other than the final one is handled
// in the main phase alone. A final subject character ends there when the
// verdict is already settled and otherwise also passes through the end and
// final phases, because the pattern store has a single read port, addressed
// by the match position, and the closing element check and the end-of-subject
// check each need the entry at a new position. The verdict sits in an output
// register, and the matcher works on while it waits, up to the next verdict.

module subject_wildcard_match_core import swm_pkg::*; #(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_symbol,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_outcome
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  swm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_symbol  (in_symbol),
    .in_last    (in_last),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  swm_back #(.PATTERN_CHARS(PATTERN_CHARS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_outcome (out_outcome)
  );

endmodule
